[hdl/chained_hash_map_core_macros.svh]
// Assertion macros shared by the checker of the chained hash map core.
// Depends on nothing; the including scope supplies clk and rst.
`ifndef CHAINED_HASH_MAP_CORE_MACROS_SVH
`define CHAINED_HASH_MAP_CORE_MACROS_SVH

// Same-cycle implication, muted during reset.
`define CHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted during reset.
`define CHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/chm_pkg.sv]
// Shared types, codes and widths of the chained hash map core.
// Used by chm_mod_unit, chained_hash_map_core and chm_checker.
package chm_pkg;

  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 7;
  localparam int S_DATA_W = 72;  // cmd + key + value, padded to bytes
  localparam int M_DATA_W = 40;  // status + found_value, padded to bytes
  localparam int MOD_STEPS = 32;
  localparam int STEP_W    = 6;

  localparam int BUCKETS_DEF = 64;
  localparam int WAYS_DEF    = 4;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 7'd64;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_ROW,
    S_RD,
    S_CMP,
    S_UPD
  } state_t;

endpackage

[hdl/chm_mod_unit.sv]
// Bit-serial restoring remainder unit: key modulo bucket count, one bit per cycle.
// Depends on chm_pkg.
module chm_mod_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [chm_pkg::KEY_W-1:0]  dividend,
  input  logic [chm_pkg::CFG_W-1:0]  divisor,
  output logic                       done,
  output logic [chm_pkg::CFG_W-1:0]  remainder
);
  import chm_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [KEY_W-1:0]  dvd;
  logic [CFG_W-1:0]  dvs;
  logic [CFG_W-1:0]  rem;
  logic [CFG_W-1:0]  rem_next;
  logic [CFG_W:0]    trial;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem, dvd[KEY_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = CFG_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(MOD_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      dvd  <= {dvd[KEY_W-2:0], 1'b0};
      rem  <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

[hdl/chained_hash_map_core.sv]
// Chained hash map core: a key-value store of BUCKETS buckets with WAYS slots each; the
// bucket is the key modulo the configured bucket count (0 acts as 1, values above BUCKETS
// act as BUCKETS). After reset the core sweeps the valid rows of all buckets to clear
// them and takes no request meanwhile. Each request then goes through these steps: the
// idle state accepts it, the bit-serial remainder unit finds the bucket, the valid row is
// read, then the ways are probed through the key and value memory read ports up to the
// first key match (S_RD for a free way, S_RD then S_CMP for an occupied way), and the
// update state writes the memories and issues the result. A result still waiting holds
// the update state of the next request. The result sits in an output register, so a new
// request is taken while the previous result waits.
// Depends on chm_pkg and chm_mod_unit.
module chained_hash_map_core #(
  parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
  parameter int WAYS    = chm_pkg::WAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: cmd[1:0], key[33:2], value[65:34], zero padding above
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [chm_pkg::S_DATA_W-1:0]  s_tdata,
  // m_tdata: status[1:0], found_value[33:2], zero padding above
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [chm_pkg::M_DATA_W-1:0]  m_tdata,
  // bucket_count register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [chm_pkg::CFG_W-1:0]     cfg_data
);
  import chm_pkg::*;

  localparam int SLOTS = BUCKETS * WAYS;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  state_t state, state_next;

  logic [CFG_W-1:0]  bucket_count;
  logic [CFG_W-1:0]  buckets_used;
  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [BW-1:0]     bucket_q;
  logic [BW-1:0]     clr_cnt;
  logic [WW-1:0]     way_cnt;
  logic [WW-1:0]     hit_way;
  logic              hit;
  logic [VAL_W-1:0]  found_q;
  logic              way_last;
  logic              key_match;

  logic              mod_start;
  logic              mod_done;
  logic [CFG_W-1:0]  mod_rem;

  logic [KEY_W-1:0]  key_mem [SLOTS];
  logic [VAL_W-1:0]  val_mem [SLOTS];
  logic [WAYS-1:0]   row_mem [BUCKETS];
  logic [KEY_W-1:0]  key_rd;
  logic [VAL_W-1:0]  val_rd;
  logic [WAYS-1:0]   row_rd;

  logic              has_free;
  logic [WW-1:0]     free_way;
  logic [WW-1:0]     mod_way;
  logic [SW-1:0]     rd_slot;
  logic [SW-1:0]     wr_slot;
  logic              key_we;
  logic              val_we;
  logic              row_we;
  logic [BW-1:0]     row_waddr;
  logic [WAYS-1:0]   row_wdata;
  logic              upd_go;
  logic [STAT_W-1:0] res_status;
  logic [VAL_W-1:0]  res_found;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign mod_start = s_tvalid && s_tready;
  assign way_last  = (way_cnt == WW'(WAYS - 1));
  assign key_match = (key_rd == key_q);
  assign upd_go    = (state == S_UPD) && (!m_tvalid || m_tready);

  always_comb begin
    buckets_used = bucket_count;
    if (bucket_count == '0) begin
      buckets_used = CFG_W'(1);
    end else if (32'(bucket_count) > BUCKETS) begin
      buckets_used = CFG_W'(BUCKETS);
    end
  end

  chm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (s_tdata[KEY_W+CMD_W-1:CMD_W]),
    .divisor   (buckets_used),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Lowest free way of the bucket.
  always_comb begin
    has_free = 1'b0;
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!row_rd[i]) begin
        has_free = 1'b1;
        free_way = WW'(i);
      end
    end
  end

  assign rd_slot = SW'(32'(bucket_q) * WAYS + 32'(way_cnt));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == BW'(BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE:  if (s_tvalid) state_next = S_DIV;
      S_DIV:   if (mod_done) state_next = S_ROW;
      S_ROW:   state_next = S_RD;
      S_RD: begin
        if (row_rd[way_cnt]) begin
          state_next = S_CMP;
        end else if (way_last) begin
          state_next = S_UPD;
        end
      end
      S_CMP: begin
        if (key_match || way_last) begin
          state_next = S_UPD;
        end else begin
          state_next = S_RD;
        end
      end
      S_UPD:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory writes and the result of the request.
  always_comb begin
    key_we     = 1'b0;
    val_we     = 1'b0;
    row_we     = 1'b0;
    row_waddr  = bucket_q;
    res_status = ST_DONE;
    res_found  = '0;
    mod_way    = hit_way;
    unique case (state)
      S_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_cnt;
      end
      S_UPD: begin
        unique case (cmd_q)
          CMD_INSERT: begin
            if (hit) begin
              val_we = upd_go;
            end else if (has_free) begin
              mod_way = free_way;
              key_we  = upd_go;
              val_we  = upd_go;
              row_we  = upd_go;
            end else begin
              res_status = ST_FULL;
            end
          end
          CMD_REMOVE: begin
            if (hit) begin
              row_we = upd_go;
            end else begin
              res_status = ST_MISSING;
            end
          end
          CMD_LOOKUP: begin
            if (hit) begin
              res_found = found_q;
            end else begin
              res_status = ST_MISSING;
            end
          end
          default: res_status = ST_DONE;
        endcase
      end
      default: row_we = 1'b0;
    endcase
  end

  assign wr_slot = SW'(32'(bucket_q) * WAYS + 32'(mod_way));

  // Set the bit on insert, drop it on remove; clear whole rows during the sweep.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      if (state == S_CLEAR) begin
        row_wdata[i] = 1'b0;
      end else if (WW'(i) == mod_way) begin
        row_wdata[i] = (cmd_q == CMD_INSERT);
      end else begin
        row_wdata[i] = row_rd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      bucket_count <= BUCKET_COUNT_RST;
      clr_cnt      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        bucket_count <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + BW'(1);
      end
      if (upd_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request datapath.
  always_ff @(posedge clk) begin
    if (mod_start) begin
      cmd_q   <= s_tdata[CMD_W-1:0];
      key_q   <= s_tdata[KEY_W+CMD_W-1:CMD_W];
      val_q   <= s_tdata[VAL_W+KEY_W+CMD_W-1:KEY_W+CMD_W];
      way_cnt <= '0;
      hit     <= 1'b0;
    end
    if (state == S_DIV && mod_done) begin
      bucket_q <= BW'(mod_rem);
    end
    if (state == S_RD && !row_rd[way_cnt] && !way_last) begin
      way_cnt <= way_cnt + WW'(1);
    end
    if (state == S_CMP) begin
      if (key_match) begin
        hit     <= 1'b1;
        hit_way <= way_cnt;
        found_q <= val_rd;
      end else if (!way_last) begin
        way_cnt <= way_cnt + WW'(1);
      end
    end
    if (upd_go) begin
      m_tdata <= {(M_DATA_W - VAL_W - STAT_W)'(0), res_found, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_slot] <= key_q;
    end
    if (state == S_RD) begin
      key_rd <= key_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_slot] <= val_q;
    end
    if (state == S_RD) begin
      val_rd <= val_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (state == S_ROW) begin
      row_rd <= row_mem[bucket_q];
    end
  end

endmodule

[hdl/chm_checker.sv]
// Port-level checker of the chained hash map core, bound to the top level.
// Depends on chm_pkg and chained_hash_map_core_macros.svh.
`include "chained_hash_map_core_macros.svh"

module chm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [chm_pkg::S_DATA_W-1:0]  s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [chm_pkg::M_DATA_W-1:0]  m_tdata
);
  import chm_pkg::*;

  `CHM_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
  `CHM_ASSERT_NOW(a_value_only_on_done, m_tvalid && m_tdata[VAL_W+STAT_W-1:STAT_W] != '0, m_tdata[STAT_W-1:0] == ST_DONE, "nonzero value with a failing status")
  `CHM_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "request taken while previous one in progress")
  `CHM_ASSERT_NOW(a_sweep_after_reset, $fell(rst), !s_tready, "request taken before the valid rows are cleared")

endmodule

bind chained_hash_map_core chm_checker u_chm_checker (.*);

[test/tb_chained_hash_map_core.sv]
// Self-checking testbench for chained_hash_map_core: directed table, then random phases.
// Depends on chm_pkg and the core RTL; results are checked against an in-bench map model.
module tb_chained_hash_map_core;
  import chm_pkg::*;

  localparam int SLOTS = BUCKETS_DEF * WAYS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int DIRECTED_ROWS = 22;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  found;
  } map_reply_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             typed;
    map_reply_t       reply;
  } directed_row_t;

  // typed rows carry the reply as read straight off the behaviour; the rest use the model
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_MISSING, 32'h0}},
    '{CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_MISSING, 32'h0}},
    '{CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_DONE, 32'h0}},
    '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_DONE, 32'hFFFF_FFFF}},
    '{CMD_INSERT, 32'h0000_0040, 32'h0000_0000, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_INSERT, 32'h0000_0080, 32'h0000_0001, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_INSERT, 32'h0000_00C0, 32'h0000_0002, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_INSERT, 32'h0000_0100, 32'h0000_0003, 1'b1, '{ST_FULL, 32'h0}},
    '{CMD_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_REMOVE, 32'h0000_0040, 32'hFFFF_FFFF, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_INSERT, 32'h0000_0100, 32'h0000_0003, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_LOOKUP, 32'h0000_0100, 32'h0000_0000, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_LOOKUP, 32'h0000_0040, 32'h0000_0000, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_DONE, 32'h0}},
    '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_INSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_INSERT, 32'h8000_0000, 32'h5555_5555, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{ST_DONE, 32'h0}},
    '{CMD_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{ST_DONE, 32'h0}}
  };

  // phase settings: extremes and out-of-range values of the bucket count among them
  localparam logic [CFG_W-1:0] PHASE_COUNT [PHASES] = '{
    7'd0, 7'd127, 7'd1, 7'd64, 7'd5, 7'd65, 7'd37, 7'd16
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;

  // map model state
  logic             slot_used [SLOTS];
  logic [KEY_W-1:0] slot_key_q [SLOTS];
  logic [VAL_W-1:0] slot_val_q [SLOTS];
  logic [CFG_W-1:0] bucket_count_q = BUCKET_COUNT_RST;

  map_reply_t       pending_replies [$];
  logic [KEY_W-1:0] key_pool [24];
  int               fail_count = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               quiet_cycles = 0;

  chained_hash_map_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int buckets_in_use();
    int n;
    n = int'(bucket_count_q);
    if (n == 0) n = 1;
    if (n > BUCKETS_DEF) n = BUCKETS_DEF;
    return n;
  endfunction

  // apply one request to the map model and return its reply
  function automatic map_reply_t apply_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                               logic [VAL_W-1:0] val);
    int base;
    int hit;
    int free_slot;
    map_reply_t r;
    base = int'(key % 32'(buckets_in_use())) * WAYS_DEF;
    hit = -1;
    free_slot = -1;
    for (int w = 0; w < WAYS_DEF; w++) begin
      if (hit < 0 && slot_used[base + w] && slot_key_q[base + w] == key) hit = base + w;
      if (free_slot < 0 && !slot_used[base + w]) free_slot = base + w;
    end
    r.status = ST_DONE;
    r.found = '0;
    case (cmd)
      CMD_INSERT: begin
        if (hit >= 0) begin
          slot_val_q[hit] = val;
        end else if (free_slot >= 0) begin
          slot_used[free_slot] = 1'b1;
          slot_key_q[free_slot] = key;
          slot_val_q[free_slot] = val;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) slot_used[hit] = 1'b0;
        else r.status = ST_MISSING;
      end
      CMD_LOOKUP: begin
        if (hit >= 0) r.found = slot_val_q[hit];
        else r.status = ST_MISSING;
      end
      default: ;
    endcase
    return r;
  endfunction

  // crowd a few buckets, revisit a pool of keys, and now and then take any key at all
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom;
    if (r < 45) return key_pool[$urandom_range(0, 23)];
    if (r < 75) return 32'($urandom_range(0, 3) + buckets_in_use() * $urandom_range(0, 7));
    return 32'($urandom_range(0, 255));
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_INSERT;
    if (r < 60) return CMD_REMOVE;
    if (r < 95) return CMD_LOOKUP;
    return CMD_UNUSED;
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val, input logic typed,
                              input map_reply_t typed_reply);
    map_reply_t predicted;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, val, key, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_request(cmd, key, val);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  // hold the sender off until every reply has come back
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] count);
    cfg_valid <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    bucket_count_q = count;
  endtask

  always @(posedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    map_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none outstanding: status %0d found_value %h", $time,
                 m_tdata[1:0], m_tdata[33:2]);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[33:2] !== want.found) begin
          $display("%0t: found_value expected %h got %h", $time, want.found, m_tdata[33:2]);
          fail_count++;
        end
      end
    end
  end

  // covers the clearing sweep after reset, a full request and long receiver stalls
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("chained_hash_map_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key_q[i] = '0;
      slot_val_q[i] = '0;
    end
    for (int i = 0; i < 24; i++) key_pool[i] = (i < 12) ? $urandom : 32'($urandom_range(0, 511));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(DIRECTED[i].cmd, DIRECTED[i].key, DIRECTED[i].value, DIRECTED[i].typed,
                   DIRECTED[i].reply);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_replies();
      write_bucket_count(PHASE_COUNT[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 39) == 0) drain_replies();
        send_request(pick_cmd(), pick_key(), $urandom, 1'b0, '0);
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("chained_hash_map_core: match");
    end else begin
      $display("chained_hash_map_core: mismatch");
    end
    $finish;
  end

endmodule
